// File: rtl/core/rc4_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// rc4_frame_receiver_macros.svh
// Assertion macros for the RC4 frame receiver.
// ----------------------------------------------------------------------------
`ifndef RC4_FRAME_RECEIVER_MACROS_SVH
`define RC4_FRAME_RECEIVER_MACROS_SVH
`ifndef SYNTHESIS
`define RFR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RFR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RFR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/rfr_pkg.sv
// ----------------------------------------------------------------------------
// rfr_pkg
// Shared types and constants for the RC4 frame receiver.
// ----------------------------------------------------------------------------
package rfr_pkg;

  localparam int MAX_PACKET = 512;
  localparam int LEN_W      = 10;

  typedef logic [3:0] status_t;
  localparam status_t ST_OK    = 4'd0;
  localparam status_t ST_TAG   = 4'd1;
  localparam status_t ST_LEN   = 4'd2;
  localparam status_t ST_CHECK = 4'd3;
  localparam status_t ST_SUM   = 4'd4;
  localparam status_t ST_SHORT = 4'd5;
  localparam status_t ST_ETX   = 4'd6;
  localparam status_t ST_CRC   = 4'd7;
  localparam status_t ST_CMD   = 4'd8;
  localparam status_t ST_TRUNC = 4'd9;

  localparam logic [0:0] CFG_KEY_LOW  = 1'b0;
  localparam logic [0:0] CFG_KEY_HIGH = 1'b1;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hffff;
  localparam logic [7:0]  ETX      = 8'h03;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_last;
    logic [3:0]  status;
    logic [15:0] command;
    logic [7:0]  reply_code;
  } out_item_t;

  // Request to the keystream unit and its answer.
  typedef struct packed {
    logic sched;   // run key schedule
    logic gen;     // produce one keystream byte
  } ks_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] ks;
  } ks_rsp_t;

  function automatic logic [7:0] tag_byte(input logic [1:0] k);
    case (k)
      2'd0: tag_byte = 8'h53;
      2'd1: tag_byte = 8'h41;
      2'd2: tag_byte = 8'h50;
      default: tag_byte = 8'h49;
    endcase
  endfunction

  function automatic logic known_cmd(input logic [15:0] c);
    case (c)
      16'h0000, 16'h0201, 16'h0202, 16'h0210, 16'h0211, 16'h0220, 16'h0240,
      16'h0280, 16'h0281, 16'h0282, 16'h0290, 16'h0291, 16'h02a0, 16'h02f0,
      16'h0601, 16'h0602, 16'h0610, 16'h0611, 16'h0620, 16'h0690, 16'h0691,
      16'h0f01, 16'h0f10, 16'h0f20: known_cmd = 1'b1;
      default: known_cmd = 1'b0;
    endcase
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] c,
                                           input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      v = v[15] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    crc_byte = v;
  endfunction

endpackage

// File: rtl/core/rc4_frame_receiver.sv
// ----------------------------------------------------------------------------
// rc4_frame_receiver
// Packet receiver: tag and length parse, RC4 payload decrypt, frame checks.
// ----------------------------------------------------------------------------
// Header bytes are taken as they arrive unless a result is held by out_stall. A
// payload byte goes from accept to the next accept through five S-box steps, a
// done step, retire and accept. A legal second length byte starts the key
// schedule, an S-box fill and a swap pass, during which no item is taken.
// Reset (synchronous, rst high) clears control state and loads the default
// key "0000000000000000"; the S-box is not cleared, it is scheduled first.
// ----------------------------------------------------------------------------
`include "rc4_frame_receiver_macros.svh"

module rc4_frame_receiver (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rfr_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rfr_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import rfr_pkg::*;

  typedef enum logic [2:0] {
    P_TAG, P_LEN, P_PAY, P_SKIP, P_SCHED, P_KS, P_OUT
  } phase_t;

  phase_t          phase;
  logic [63:0]     key_low, key_high;
  logic [127:0]    key_all;
  logic [LEN_W:0]  byte_count;
  logic [LEN_W:0]  payload_length;
  logic [7:0]      len_hi;
  logic [31:0]     byte_sum;
  logic [15:0]     crc_acc;
  logic [7:0]      tail0, tail1, tail2;
  logic [15:0]     first_inner;
  status_t         fault_code;
  in_item_t        cur;
  ks_req_t         ks_req;
  ks_rsp_t         ks_rsp;
  logic            accept;

  // Payload-byte working values.
  logic [7:0]      d;
  logic [LEN_W:0]  sum_at, mlen, m;
  logic [7:0]      sum_byte;
  logic [LEN_W:0]  cnt_next;
  logic [16:0]     len_full;
  logic [31:0]     sum_next;

  assign key_all = {key_high, key_low};

  rfr_keystream u_ks (
    .clk(clk), .rst(rst), .key(key_all),
    .req(ks_req), .rsp(ks_rsp)
  );

  // The result slot frees up in the cycle its item is taken.
  assign accept   = in_valid && !in_stall;
  assign in_stall = !((phase == P_TAG) || (phase == P_LEN) ||
                      (phase == P_PAY) || (phase == P_SKIP)) ||
                    (out_valid && out_stall);

  assign ks_req.sched = accept && (phase == P_LEN) && (byte_count != '0) &&
                        (len_full >= 17'd8) && (len_full <= 17'(MAX_PACKET));
  assign ks_req.gen   = accept && (phase == P_PAY);

  assign len_full = {1'b0, len_hi, in_data.rx_byte};
  assign d        = cur.rx_byte ^ ks_rsp.ks;
  assign sum_at   = payload_length - (LEN_W+1)'(4);
  assign mlen     = payload_length - (LEN_W+1)'(8);
  assign m        = byte_count - (LEN_W+1)'(4);
  assign cnt_next = byte_count + (LEN_W+1)'(1);
  assign sum_next = (byte_count < sum_at) ? byte_sum + 32'(d) : byte_sum;

  always_comb begin
    case (2'(byte_count - sum_at))
      2'd0:    sum_byte = byte_sum[31:24];
      2'd1:    sum_byte = byte_sum[23:16];
      2'd2:    sum_byte = byte_sum[15:8];
      default: sum_byte = byte_sum[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_TAG;
      key_low <= 64'h3030303030303030; key_high <= 64'h3030303030303030;
      out_valid <= 1'b0;
      byte_count <= '0; payload_length <= '0; len_hi <= '0;
      byte_sum <= '0; crc_acc <= CRC_INIT; fault_code <= ST_OK;
      tail0 <= '0; tail1 <= '0; tail2 <= '0; first_inner <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY_LOW:  key_low  <= cfg_data;
          CFG_KEY_HIGH: key_high <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;

      unique case (phase)
        P_SKIP: if (accept && in_data.chunk_end) phase <= P_TAG;
        P_TAG: if (accept) begin
          if (in_data.rx_byte != tag_byte(byte_count[1:0])) begin
            out_valid <= 1'b1;
            out_data  <= '{8'd0, 1'b1, ST_TAG, 16'd0, 8'd0};
            phase     <= in_data.chunk_end ? P_TAG : P_SKIP;
            byte_count <= '0;
          end else if (in_data.chunk_end) begin
            out_valid <= 1'b1;
            out_data  <= '{8'd0, 1'b1, ST_TRUNC, 16'd0, 8'd0};
            byte_count <= '0;
          end else if (byte_count == (LEN_W+1)'(3)) begin
            byte_count <= '0; phase <= P_LEN;
          end else begin
            byte_count <= cnt_next;
          end
        end
        P_LEN: if (accept) begin
          if (byte_count == '0) begin
            len_hi <= in_data.rx_byte;
            if (in_data.chunk_end) begin
              out_valid <= 1'b1;
              out_data  <= '{8'd0, 1'b1, ST_TRUNC, 16'd0, 8'd0};
              phase <= P_TAG;
            end else begin
              byte_count <= (LEN_W+1)'(1);
            end
          end else begin
            byte_count <= '0;
            if (!ks_req.sched) begin
              out_valid <= 1'b1;
              out_data  <= '{8'd0, 1'b1, ST_LEN, 16'd0, 8'd0};
              phase <= in_data.chunk_end ? P_TAG : P_SKIP;
            end else begin
              payload_length <= len_full[LEN_W:0];
              cur <= in_data;
              phase <= P_SCHED;
            end
          end
        end
        P_SCHED: if (ks_rsp.done) begin
          if (cur.chunk_end) begin
            out_valid <= 1'b1;
            out_data  <= '{8'd0, 1'b1, ST_TRUNC, 16'd0, 8'd0};
            phase <= P_TAG;
          end else begin
            phase <= P_PAY;
          end
        end
        P_PAY: if (accept) begin
          cur <= in_data; phase <= P_KS;
        end
        P_KS: if (ks_rsp.done) begin
          phase <= P_OUT;
        end
        P_OUT: begin
          // Retire one payload byte.
          logic       fault;
          logic       emit_data;
          status_t    fc;
          logic [7:0] t0, t1, t2;
          logic [15:0] fi, crc, given;
          fault = 1'b0; emit_data = 1'b0; fc = fault_code;
          t0 = tail0; t1 = tail1; t2 = tail2; fi = first_inner; crc = crc_acc;
          byte_sum <= sum_next;
          if (byte_count < (LEN_W+1)'(4)) begin
            fault = (d != key_all[{byte_count[3:0], 3'b000} +: 8]);
          end else if (byte_count < sum_at) begin
            if (m == '0) fi = {d, 8'd0};
            else if (m == (LEN_W+1)'(1)) fi = {fi[15:8], d};
            if (m + (LEN_W+1)'(3) < mlen) crc = crc_byte(crc, d);
            t2 = t1; t1 = t0; t0 = d;
            emit_data = 1'b1;
          end else if (d != sum_byte && fc == ST_OK) begin
            fc = ST_SUM;
          end
          tail0 <= t0; tail1 <= t1; tail2 <= t2; first_inner <= fi;
          crc_acc <= crc; fault_code <= fc; byte_count <= cnt_next;
          given = {t1, t2};
          out_valid <= 1'b0;
          if (fault || cnt_next >= payload_length || cur.chunk_end) begin
            out_valid <= 1'b1;
            byte_count <= '0; byte_sum <= '0; crc_acc <= CRC_INIT;
            tail0 <= '0; tail1 <= '0; tail2 <= '0; first_inner <= '0;
            fault_code <= ST_OK;
            phase <= cur.chunk_end ? P_TAG : P_SKIP;
            if (fault)
              out_data <= '{8'd0, 1'b1, ST_CHECK, 16'd0, 8'd0};
            else if (cnt_next < payload_length)
              out_data <= '{8'd0, 1'b1, ST_TRUNC, 16'd0, 8'd0};
            else if (fc != ST_OK)
              out_data <= '{8'd0, 1'b1, fc, 16'd0, 8'd0};
            else if (mlen < (LEN_W+1)'(9))
              out_data <= '{8'd0, 1'b1, ST_SHORT, 16'd0,
                            (mlen != '0) ? fi[15:8] : 8'd0};
            else if (t0 != ETX)
              out_data <= '{8'd0, 1'b1, ST_ETX, 16'd0, 8'd0};
            else if (given != crc)
              out_data <= '{8'd0, 1'b1, ST_CRC, 16'd0, 8'd0};
            else if (known_cmd(fi))
              out_data <= '{8'd0, 1'b1, ST_OK, fi, 8'd0};
            else
              out_data <= '{8'd0, 1'b1, ST_CMD, 16'd0, 8'd0};
          end else begin
            phase <= P_PAY;
            if (emit_data) begin
              out_valid <= 1'b1;
              out_data  <= '{d, 1'b0, ST_OK, 16'd0, 8'd0};
            end
          end
        end
        default: phase <= P_TAG;
      endcase
    end
  end

  // No item is taken while the key schedule or a keystream byte is running.
  `RFR_ASSERT_IMPL(a_no_accept_busy, clk, rst,
    (phase == P_SCHED || phase == P_KS || phase == P_OUT), !accept)
  // A data item never carries a nonzero status.
  `RFR_ASSERT_IMPL(a_data_status, clk, rst,
    (out_valid && !out_data.is_last), out_data.status == ST_OK)
  // An accepted payload byte is followed by the keystream wait phase.
  `RFR_ASSERT_NEXT(a_ks_follow, clk, rst, (accept && phase == P_PAY),
    phase == P_KS)
endmodule

// File: rtl/core/rfr_ram.sv
// ----------------------------------------------------------------------------
// rfr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module rfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/rfr_keystream.sv
// ----------------------------------------------------------------------------
// rfr_keystream
// RC4 S-box engine: key schedule and keystream bytes over one S-box RAM.
// ----------------------------------------------------------------------------
module rfr_keystream (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [127:0]          key,
  input  rfr_pkg::ks_req_t      req,
  output rfr_pkg::ks_rsp_t      rsp
);
  import rfr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_KA, S_KB, S_KC, S_KD,
    S_GA, S_GB, S_GC, S_GD, S_GE
  } state_t;

  state_t     state;
  logic [7:0] a;      // schedule index / idx_i
  logic [7:0] j;
  logic [7:0] si;     // S[i]
  logic [7:0] sj;     // S[j]
  logic       done;
  logic [7:0] ks;
  logic       fwd;    // output index hits the S[j] write of the same cycle

  logic       we;
  logic [7:0] waddr, wdata, raddr, rdata;
  logic [7:0] kb;
  logic [7:0] j_sum;

  rfr_ram #(.WIDTH(8), .DEPTH(256)) u_sbox (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign kb    = key[{a[3:0], 3'b000} +: 8];
  assign j_sum = j + rdata + ((state == S_KB) ? kb : 8'd0);

  always_comb begin
    we = 1'b0; waddr = a; wdata = a; raddr = a;
    unique case (state)
      S_FILL: begin we = 1'b1; end
      S_KA:   begin raddr = a; end                  // read S[a]
      S_KB:   begin raddr = j_sum; end              // read S[j]
      S_KC:   begin we = 1'b1; waddr = a; wdata = rdata; end
      S_KD:   begin we = 1'b1; waddr = j; wdata = si; end
      S_GA:   begin raddr = a; end                  // read S[i]
      S_GB:   begin raddr = j_sum; end              // read S[j]
      S_GC:   begin we = 1'b1; waddr = a; wdata = rdata; end
      S_GD:   begin we = 1'b1; waddr = j; wdata = si;
                    raddr = si + sj; end
      S_GE:   begin end
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      a <= '0; j <= '0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.sched) begin
            a <= '0; state <= S_FILL;
          end else if (req.gen) begin
            a <= a + 8'd1; state <= S_GA;
          end
        end
        S_FILL: begin
          a <= a + 8'd1;
          if (a == 8'hff) begin
            j <= '0; state <= S_KA;
          end
        end
        S_KA: state <= S_KB;
        S_KB: begin si <= rdata; j <= j_sum; state <= S_KC; end
        S_KC: begin sj <= rdata; state <= S_KD; end
        S_KD: begin
          a <= a + 8'd1;
          if (a == 8'hff) begin
            j <= '0; state <= S_IDLE; done <= 1'b1;
          end else begin
            state <= S_KA;
          end
        end
        S_GA: state <= S_GB;
        S_GB: begin si <= rdata; j <= j_sum; state <= S_GC; end
        S_GC: begin sj <= rdata; state <= S_GD; end
        S_GD: begin fwd <= (8'(si + sj) == j); state <= S_GE; end
        S_GE: begin ks <= fwd ? si : rdata; done <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.ks   = ks;
endmodule

// File: dv/tb_rc4_frame_receiver.sv
// ----------------------------------------------------------------------------
// tb_rc4_frame_receiver
// Self-checking bench for the RC4 frame receiver.
// ----------------------------------------------------------------------------
// A short table of hand-made rows opens the run: bad tag, early chunk end,
// lengths just outside the legal range, and an empty message. After that,
// random packets are built, encrypted under the current key and sometimes
// damaged. A model of the block, kept inside the bench, predicts every item.
// Both sides idle in random bursts. The receiver holds off once for a long
// stretch. The key is changed between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_rc4_frame_receiver;
  import rfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 8000;
  localparam int LONG_HOLD      = 300;
  localparam int PHASE_ITEMS    = 270;

  typedef enum int {PH_TAG, PH_LEN, PH_PAY, PH_SKIP} rx_phase_e;

  typedef struct {
    in_item_t  it;
    bit        typed;   // expected verdict written into the table
    out_item_t exp;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_KEY_LOW;
  logic [63:0] cfg_data = '0;

  rc4_frame_receiver dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shared run state.
  out_item_t pending_results[$];
  stim_row_t stim_rows[$];
  int        fail_count = 0;
  bit        quiet = 1'b0;      // no idling in the closing part
  bit        hold_req = 1'b0;   // ask the receiver for one long hold-off
  int        big_packets = 0;

  // --------------------------------------------------------------------------
  // Frame model: mirrors the block's state, item by item.
  // --------------------------------------------------------------------------
  logic [7:0]  tag_ascii [4] = '{8'h53, 8'h41, 8'h50, 8'h49};
  logic [15:0] cmd_list [24] = '{
    16'h0000, 16'h0201, 16'h0202, 16'h0210, 16'h0211, 16'h0220, 16'h0240,
    16'h0280, 16'h0281, 16'h0282, 16'h0290, 16'h0291, 16'h02a0, 16'h02f0,
    16'h0601, 16'h0602, 16'h0610, 16'h0611, 16'h0620, 16'h0690, 16'h0691,
    16'h0f01, 16'h0f10, 16'h0f20};

  logic [63:0] key_lo = 64'h3030303030303030;
  logic [63:0] key_hi = 64'h3030303030303030;
  logic [7:0]  m_sbox [256];
  logic [7:0]  m_i, m_j;
  rx_phase_e   m_phase = PH_TAG;
  int          m_count, m_len;
  logic [31:0] m_sum;
  logic [15:0] m_crc;
  logic [7:0]  m_tail [4];
  logic [15:0] m_first;
  logic [3:0]  m_fault;

  function automatic logic [7:0] key_at(int k);
    logic [127:0] kk;
    kk = {key_hi, key_lo};
    return kk[8*(k % 16) +: 8];
  endfunction

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] v;
    v = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) v = v[15] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    return v;
  endfunction

  function automatic bit cmd_known(logic [15:0] c);
    foreach (cmd_list[k]) if (cmd_list[k] == c) return 1'b1;
    return 1'b0;
  endfunction

  task automatic clear_frame();
    m_count = 0; m_len = 0; m_sum = '0; m_crc = CRC_INIT;
    foreach (m_tail[k]) m_tail[k] = '0;
    m_first = '0; m_fault = '0;
  endtask

  task automatic load_sbox();
    logic [7:0] j, t;
    j = '0;
    for (int a = 0; a < 256; a++) m_sbox[a] = a[7:0];
    for (int a = 0; a < 256; a++) begin
      j = j + m_sbox[a] + key_at(a);
      t = m_sbox[a]; m_sbox[a] = m_sbox[j]; m_sbox[j] = t;
    end
    m_i = '0; m_j = '0;
  endtask

  function automatic logic [7:0] next_ks();
    logic [7:0] t;
    m_i = m_i + 8'd1;
    m_j = m_j + m_sbox[m_i];
    t = m_sbox[m_i]; m_sbox[m_i] = m_sbox[m_j]; m_sbox[m_j] = t;
    t = m_sbox[m_i] + m_sbox[m_j];
    return m_sbox[t];
  endfunction

  // Verdict: the packet closes; skip the rest of the chunk unless it ends here.
  task automatic close_frame(logic [3:0] st, logic [15:0] cmd, logic [7:0] rc,
                             bit chunk_done, output bit got, output out_item_t r);
    m_phase = chunk_done ? PH_TAG : PH_SKIP;
    clear_frame();
    got = 1'b1;
    r = '0;
    r.is_last = 1'b1; r.status = st; r.command = cmd; r.reply_code = rc;
  endtask

  task automatic judge_frame(bit e, output bit got, output out_item_t r);
    int mlen;
    mlen = m_len - 8;
    if (m_fault != 0) close_frame(m_fault, '0, '0, e, got, r);
    else if (mlen < 9)
      close_frame(ST_SHORT, '0, (mlen != 0) ? m_first[15:8] : 8'h00, e, got, r);
    else if (m_tail[0] != ETX) close_frame(ST_ETX, '0, '0, e, got, r);
    else if ({m_tail[1], m_tail[2]} != m_crc) close_frame(ST_CRC, '0, '0, e, got, r);
    else if (cmd_known(m_first)) close_frame(ST_OK, m_first, '0, e, got, r);
    else close_frame(ST_CMD, '0, '0, e, got, r);
  endtask

  task automatic predict_item(in_item_t it, output bit got, output out_item_t r);
    logic [7:0] b, d;
    bit e;
    int p, sum_at, m;
    b = it.rx_byte; e = it.chunk_end;
    got = 1'b0; r = '0;
    case (m_phase)
      PH_SKIP: begin
        if (e) m_phase = PH_TAG;
      end
      PH_TAG: begin
        if (b != tag_ascii[m_count % 4]) begin
          close_frame(ST_TAG, '0, '0, e, got, r);
          return;
        end
        m_count++;
        if (m_count >= 4) begin
          m_count = 0; m_phase = PH_LEN;
        end
        if (e) close_frame(ST_TRUNC, '0, '0, 1'b1, got, r);
      end
      PH_LEN: begin
        if (m_count == 0) begin
          m_len = int'(b); m_count = 1;
          if (e) close_frame(ST_TRUNC, '0, '0, 1'b1, got, r);
          return;
        end
        m_len = (m_len << 8) | int'(b);
        if (m_len < 8 || m_len > MAX_PACKET) begin
          close_frame(ST_LEN, '0, '0, e, got, r);
          return;
        end
        load_sbox();
        m_count = 0; m_phase = PH_PAY;
        if (e) close_frame(ST_TRUNC, '0, '0, 1'b1, got, r);
      end
      default: begin
        p = m_count; sum_at = m_len - 4;
        d = b ^ next_ks();
        if (p < sum_at) m_sum += 32'(d);
        if (p < 4) begin
          if (d != key_at(p)) begin
            close_frame(ST_CHECK, '0, '0, e, got, r);
            return;
          end
        end else if (p < sum_at) begin
          m = p - 4;
          if (m == 0) m_first = {d, 8'h00};
          else if (m == 1) m_first[7:0] = d;
          if (m + 3 < m_len - 8) m_crc = crc_step(m_crc, d);
          m_tail[3] = m_tail[2]; m_tail[2] = m_tail[1];
          m_tail[1] = m_tail[0]; m_tail[0] = d;
          got = 1'b1; r.out_byte = d;
        end else begin
          if (d != m_sum[8*(3 - ((p - sum_at) % 4)) +: 8] && m_fault == 0)
            m_fault = ST_SUM;
        end
        m_count = p + 1;
        if (m_count >= m_len) judge_frame(e, got, r);
        else if (e) close_frame(ST_TRUNC, '0, '0, 1'b1, got, r);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Packet builder: encrypts under the current key with its own RC4 state.
  // --------------------------------------------------------------------------
  task automatic keystream_for(int n, output logic [7:0] ks[$]);
    logic [7:0] s [256];
    logic [7:0] i, j, t;
    ks = {};
    j = '0;
    for (int a = 0; a < 256; a++) s[a] = a[7:0];
    for (int a = 0; a < 256; a++) begin
      j = j + s[a] + key_at(a);
      t = s[a]; s[a] = s[j]; s[j] = t;
    end
    i = '0; j = '0;
    repeat (n) begin
      i = i + 8'd1; j = j + s[i];
      t = s[i]; s[i] = s[j]; s[j] = t;
      t = s[i] + s[j];
      ks.push_back(s[t]);
    end
  endtask

  task automatic add_row(logic [7:0] b, bit e, bit typed = 1'b0,
                         logic [3:0] st = ST_OK);
    stim_row_t row;
    row.it.rx_byte = b; row.it.chunk_end = e; row.typed = typed;
    row.exp = '0; row.exp.is_last = 1'b1; row.exp.status = st;
    stim_rows.push_back(row);
  endtask

  // Builds one frame of mlen inner bytes; damage is chosen at random when
  // spoil is set.
  task automatic add_packet(int mlen, bit spoil);
    logic [7:0] msg[$], body[$], raw[$], ks[$];
    logic [15:0] crc, cmd;
    logic [31:0] sum;
    int plen, r;
    msg = {};
    for (int k = 0; k < mlen; k++) msg.push_back(8'($urandom_range(0, 255)));
    if (mlen >= 9) begin
      cmd = ($urandom_range(0, 4) != 0) ? cmd_list[$urandom_range(0, 23)]
                                         : 16'($urandom_range(0, 65535));
      msg[0] = cmd[15:8]; msg[1] = cmd[7:0];
      crc = CRC_INIT;
      for (int k = 0; k < mlen - 3; k++) crc = crc_step(crc, msg[k]);
      msg[mlen-3] = crc[7:0]; msg[mlen-2] = crc[15:8]; msg[mlen-1] = ETX;
    end
    body = {};
    for (int k = 0; k < 4; k++) body.push_back(key_at(k));
    body = {body, msg};
    sum = '0;
    foreach (body[k]) sum += 32'(body[k]);
    body = {body, sum[31:24], sum[23:16], sum[15:8], sum[7:0]};
    plen = body.size();
    keystream_for(plen, ks);
    raw = {tag_ascii[0], tag_ascii[1], tag_ascii[2], tag_ascii[3],
           8'(plen >> 8), 8'(plen)};
    foreach (body[k]) raw.push_back(body[k] ^ ks[k]);
    if (spoil) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        raw[$urandom_range(0, raw.size() - 1)] ^= 8'($urandom_range(1, 255));
      else if (r < 75) raw = raw[0 : $urandom_range(0, raw.size() - 2)];
      else repeat ($urandom_range(1, 4)) raw.push_back(8'($urandom_range(0, 255)));
    end
    foreach (raw[k]) add_row(raw[k], k == raw.size() - 1);
  endtask

  task automatic add_random_traffic();
    int r, mlen, n;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      // line noise
      n = $urandom_range(1, 8);
      for (int k = 0; k < n; k++) add_row(8'($urandom_range(0, 255)), k == n - 1);
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 10) mlen = $urandom_range(0, 8);
    else if (r < 12 && big_packets < 2) begin
      mlen = MAX_PACKET - 8;
      big_packets++;
    end else mlen = $urandom_range(9, 40);
    add_packet(mlen, $urandom_range(0, 99) < 35);
  endtask

  // --------------------------------------------------------------------------
  // Driving: sender, receiver stall, configuration writes.
  // --------------------------------------------------------------------------
  task automatic send_row(stim_row_t row);
    bit got;
    out_item_t r;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= row.it;
    do @(posedge clk); while (in_stall);
    predict_item(row.it, got, r);
    if (row.typed) pending_results.push_back(row.exp);
    else if (got) pending_results.push_back(r);
  endtask

  task automatic drain_rows();
    while (stim_rows.size() != 0) send_row(stim_rows.pop_front());
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Block must be idle: all verdicts in, then room for trailing skip bytes.
  task automatic write_key(logic [63:0] lo, logic [63:0] hi);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_KEY_LOW; cfg_data <= lo;
    @(negedge clk);
    cfg_index <= CFG_KEY_HIGH; cfg_data <= hi;
    @(negedge clk);
    cfg_we <= 1'b0;
    key_lo = lo; key_hi = hi;
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (LONG_HOLD) @(negedge clk);
      out_stall <= 1'b0;
      hold_req = 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Checking: each accepted result against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %p", $time, out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.is_last !== want.is_last ||
            out_data.status !== want.status || out_data.command !== want.command ||
            out_data.reply_code !== want.reply_code) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, want, out_data);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no handshake on either side.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || cfg_we)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog timeout", $time);
      $display("Simulation FAILED");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  logic [63:0] phase_lo [4];
  logic [63:0] phase_hi [4];

  initial begin
    int sent;
    m_phase = PH_TAG;
    clear_frame();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows under the default key.
    add_row(8'h5a, 1'b1, 1'b1, ST_TAG);
    add_row(tag_ascii[0], 1'b1, 1'b1, ST_TRUNC);
    foreach (tag_ascii[k]) add_row(tag_ascii[k], 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h07, 1'b1, 1'b1, ST_LEN);   // one below the shortest frame
    foreach (tag_ascii[k]) add_row(tag_ascii[k], 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h01, 1'b1, 1'b1, ST_LEN);   // one above the longest frame
    add_packet(0, 1'b0);                  // empty message: short reply, code 0
    drain_rows();

    phase_lo = '{64'h0, 64'hffff_ffff_ffff_ffff, {$urandom, $urandom},
                 {$urandom, $urandom}};
    phase_hi = '{64'h0, 64'hffff_ffff_ffff_ffff, {$urandom, $urandom},
                 64'hffff_ffff_ffff_ffff};
    for (int ph = 0; ph < 4; ph++) begin
      // Sender pause until the block has handed over every verdict.
      write_key(phase_lo[ph], phase_hi[ph]);
      if (ph == 1) hold_req = 1'b1;
      quiet = (ph == 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        add_random_traffic();
        sent += stim_rows.size();
        drain_rows();
      end
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
